[rtl/core/pfd_pkg.sv]
// Shared types and constants of the project file event deframer.
`timescale 1ns / 1ps
`default_nettype none

package pfd_pkg;

    // Parser phases.
    typedef enum logic [3:0] {
        PH_MAGIC     = 4'd0,
        PH_HLEN      = 4'd1,
        PH_TYPE      = 4'd2,
        PH_CHAN      = 4'd3,
        PH_PPQ       = 4'd4,
        PH_CHUNK_ID  = 4'd5,
        PH_CHUNK_LEN = 4'd6,
        PH_SKIP      = 4'd7,
        PH_EV_ID     = 4'd8,
        PH_DATA      = 4'd9,
        PH_VARINT    = 4'd10,
        PH_PAYLOAD   = 4'd11,
        PH_ERROR     = 4'd12,
        PH_DONE      = 4'd13
    } t_phase;

    // Result kinds.
    localparam logic [2:0] RK_FIXED   = 3'd0;
    localparam logic [2:0] RK_TEXTLEN = 3'd1;
    localparam logic [2:0] RK_PAYLOAD = 3'd2;
    localparam logic [2:0] RK_HEADER  = 3'd3;
    localparam logic [2:0] RK_ERROR   = 3'd4;

    // Error kinds.
    localparam logic [2:0] ERR_MAGIC     = 3'd0;
    localparam logic [2:0] ERR_HLEN      = 3'd1;
    localparam logic [2:0] ERR_TYPE      = 3'd2;
    localparam logic [2:0] ERR_CHANNELS  = 3'd3;
    localparam logic [2:0] ERR_CHUNK_LEN = 3'd4;
    localparam logic [2:0] ERR_EARLY_END = 3'd5;

    // Configuration register indexes.
    localparam logic [1:0] CFG_WORD_START  = 2'd0;
    localparam logic [1:0] CFG_DWORD_START = 2'd1;
    localparam logic [1:0] CFG_TEXT_START  = 2'd2;

    // Configuration reset values.
    localparam logic [7:0] WORD_START_RST  = 8'd64;
    localparam logic [7:0] DWORD_START_RST = 8'd128;
    localparam logic [7:0] TEXT_START_RST  = 8'd192;

    // Little-endian chunk ids and fixed header fields.
    localparam logic [31:0] MAGIC_HEADER = 32'h6468_4C46;
    localparam logic [31:0] MAGIC_DATA   = 32'h7464_4C46;
    localparam logic [31:0] HDR_LENGTH   = 32'd6;

    // LEB128 shift saturation point and step.
    localparam logic [5:0] VARINT_STEP    = 6'd7;
    localparam logic [5:0] VARINT_SHIFT_MAX = 6'd35;

endpackage

`default_nettype wire

[rtl/core/pfd_in_if.sv]
// Input byte channel of the deframer: valid, ready and one file byte.
`timescale 1ns / 1ps
`default_nettype none

interface pfd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_file;

    modport source (output valid, output data_byte, output end_of_file, input ready);
    modport sink   (input valid, input data_byte, input end_of_file, output ready);
endinterface

`default_nettype wire

[rtl/core/pfd_out_if.sv]
// Result channel of the deframer: valid, ready and one result item.
`timescale 1ns / 1ps
`default_nettype none

interface pfd_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  result_kind;
    logic [7:0]  event_code;
    logic [31:0] event_value;
    logic [2:0]  error_kind;
    logic        payload_last;

    modport source (output valid, output result_kind, output event_code, output event_value,
                    output error_kind, output payload_last, input ready);
    modport sink   (input valid, input result_kind, input event_code, input event_value,
                    input error_kind, input payload_last, output ready);
endinterface

`default_nettype wire

[rtl/core/project_file_event_deframer.sv]
// An accepted byte waits in the input register; its parsed result goes to the result register.
// Throughput: one byte per cycle unless output stalls; one parse stage between two registers.
// The input register refills in the same cycle it drains, so both sides stream without gaps.
// Reset (synchronous, active low) returns the parser to the magic phase and loads the
// event class thresholds with 64, 128 and 192; errors and end of file hold until reset.
`timescale 1ns / 1ps
`default_nettype none

module project_file_event_deframer #(
    parameter int MAX_CHANNELS            = 1000,
    parameter int CHUNK_LENGTH_LIMIT_BITS = 28
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    pfd_in_if.sink     i_in,
    pfd_out_if.source  o_out,
    input  wire        i_cfg_we,
    input  wire [1:0]  i_cfg_index,
    input  wire [7:0]  i_cfg_data
);

    // The channel limit compared in the channel count check.
    localparam logic [15:0] CHAN_LIMIT = 16'(MAX_CHANNELS);

    // Configuration: event class thresholds.
    logic [7:0] r_word_start;
    logic [7:0] r_dword_start;
    logic [7:0] r_text_start;

    // Input register holding the request waiting to be parsed.
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_eof;

    // Parser state.
    pfd_pkg::t_phase r_phase, n_phase;
    logic [2:0]  r_pos, n_pos;
    logic [31:0] r_acc, n_acc;
    logic [7:0]  r_event, n_event;
    logic [5:0]  r_shift, n_shift;
    logic [31:0] r_remaining, n_remaining;
    logic [15:0] r_channels, n_channels;

    // Result register.
    logic        r_out_valid;
    logic [2:0]  r_out_kind;
    logic [7:0]  r_out_code;
    logic [31:0] r_out_value;
    logic [2:0]  r_out_err;
    logic        r_out_last;

    // Parse stage outputs.
    logic        res_valid;
    logic [2:0]  res_kind;
    logic [7:0]  res_code;
    logic [31:0] res_value;
    logic [2:0]  res_err;
    logic        res_last;

    // The parse stage moves when a request waits and the result register is free or draining.
    logic proc_fire;
    assign proc_fire  = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || proc_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_start  <= pfd_pkg::WORD_START_RST;
            r_dword_start <= pfd_pkg::DWORD_START_RST;
            r_text_start  <= pfd_pkg::TEXT_START_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                pfd_pkg::CFG_WORD_START:  r_word_start  <= i_cfg_data;
                pfd_pkg::CFG_DWORD_START: r_dword_start <= i_cfg_data;
                pfd_pkg::CFG_TEXT_START:  r_text_start  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_valid <= 1'b1;
        end else if (proc_fire) begin
            r_in_valid <= 1'b0;
        end
        if (i_in.valid && i_in.ready) begin
            r_in_byte <= i_in.data_byte;
            r_in_eof  <= i_in.end_of_file;
        end
    end

    // Parse one byte against the current state.
    always_comb begin
        logic [31:0] byte_lane;
        logic [31:0] gather_acc;
        logic [31:0] gather_len;
        logic [31:0] varint_bits;
        logic [2:0]  pos_inc;
        logic [5:0]  shift_inc;
        logic        done2;
        logic        done4;
        logic        active;
        logic        boundary;
        logic        fail;
        logic [2:0]  fail_kind;

        pos_inc    = r_pos + 3'd1;
        done2      = pos_inc >= 3'd2;
        done4      = pos_inc >= 3'd4;
        byte_lane  = {24'd0, r_in_byte} << {r_pos[1:0], 3'b000};
        gather_acc = ((r_pos == 3'd0) ? 32'd0 : r_acc) | byte_lane;
        gather_len = ((r_pos == 3'd0) ? 32'd0 : r_remaining) | byte_lane;
        varint_bits = (r_shift < 6'd32) ? ({25'd0, r_in_byte[6:0]} << r_shift[4:0]) : 32'd0;
        shift_inc  = r_shift + pfd_pkg::VARINT_STEP;

        n_phase     = r_phase;
        n_pos       = r_pos;
        n_acc       = r_acc;
        n_event     = r_event;
        n_shift     = r_shift;
        n_remaining = r_remaining;
        n_channels  = r_channels;

        res_valid = 1'b0;
        res_kind  = pfd_pkg::RK_FIXED;
        res_code  = 8'd0;
        res_value = 32'd0;
        res_err   = pfd_pkg::ERR_MAGIC;
        res_last  = 1'b0;

        active    = 1'b1;
        boundary  = 1'b0;
        fail      = 1'b0;
        fail_kind = pfd_pkg::ERR_MAGIC;

        unique case (r_phase)
            pfd_pkg::PH_MAGIC: begin
                n_acc = gather_acc;
                n_pos = done4 ? 3'd0 : pos_inc;
                if (done4) begin
                    if (gather_acc != pfd_pkg::MAGIC_HEADER) begin
                        fail      = 1'b1;
                        fail_kind = pfd_pkg::ERR_MAGIC;
                    end else begin
                        n_phase = pfd_pkg::PH_HLEN;
                    end
                end
            end
            pfd_pkg::PH_HLEN: begin
                n_acc = gather_acc;
                n_pos = done4 ? 3'd0 : pos_inc;
                if (done4) begin
                    if (gather_acc != pfd_pkg::HDR_LENGTH) begin
                        fail      = 1'b1;
                        fail_kind = pfd_pkg::ERR_HLEN;
                    end else begin
                        n_phase = pfd_pkg::PH_TYPE;
                    end
                end
            end
            pfd_pkg::PH_TYPE: begin
                n_acc = gather_acc;
                n_pos = done2 ? 3'd0 : pos_inc;
                if (done2) begin
                    if (gather_acc != 32'd0) begin
                        fail      = 1'b1;
                        fail_kind = pfd_pkg::ERR_TYPE;
                    end else begin
                        n_phase = pfd_pkg::PH_CHAN;
                    end
                end
            end
            pfd_pkg::PH_CHAN: begin
                n_acc = gather_acc;
                n_pos = done2 ? 3'd0 : pos_inc;
                if (done2) begin
                    if (gather_acc[15:0] == 16'd0 || gather_acc[15:0] > CHAN_LIMIT) begin
                        fail      = 1'b1;
                        fail_kind = pfd_pkg::ERR_CHANNELS;
                    end else begin
                        n_channels = gather_acc[15:0];
                        n_phase    = pfd_pkg::PH_PPQ;
                    end
                end
            end
            pfd_pkg::PH_PPQ: begin
                n_acc = gather_acc;
                n_pos = done2 ? 3'd0 : pos_inc;
                if (done2) begin
                    res_valid = 1'b1;
                    res_kind  = pfd_pkg::RK_HEADER;
                    res_value = {gather_acc[15:0], r_channels};
                    n_phase   = pfd_pkg::PH_CHUNK_ID;
                end
            end
            pfd_pkg::PH_CHUNK_ID: begin
                n_acc = gather_acc;
                n_pos = done4 ? 3'd0 : pos_inc;
                if (done4) begin
                    n_phase = pfd_pkg::PH_CHUNK_LEN;
                end
            end
            pfd_pkg::PH_CHUNK_LEN: begin
                n_remaining = gather_len;
                n_pos       = done4 ? 3'd0 : pos_inc;
                if (done4) begin
                    // The length limit is checked before the chunk id.
                    if ((gather_len >> CHUNK_LENGTH_LIMIT_BITS) != 32'd0) begin
                        fail      = 1'b1;
                        fail_kind = pfd_pkg::ERR_CHUNK_LEN;
                    end else if (r_acc == pfd_pkg::MAGIC_DATA) begin
                        n_phase  = pfd_pkg::PH_EV_ID;
                        boundary = 1'b1;
                    end else if (gather_len == 32'd0) begin
                        n_phase = pfd_pkg::PH_CHUNK_ID;
                    end else begin
                        n_phase = pfd_pkg::PH_SKIP;
                    end
                end
            end
            pfd_pkg::PH_SKIP: begin
                n_remaining = r_remaining - 32'd1;
                if (n_remaining == 32'd0) begin
                    n_phase = pfd_pkg::PH_CHUNK_ID;
                end
            end
            pfd_pkg::PH_EV_ID: begin
                n_event = r_in_byte;
                n_acc   = 32'd0;
                n_pos   = 3'd0;
                // Thresholds are tested from the highest class down.
                if (r_in_byte >= r_text_start) begin
                    n_shift = 6'd0;
                    n_phase = pfd_pkg::PH_VARINT;
                end else begin
                    if (r_in_byte >= r_dword_start) begin
                        n_remaining = 32'd4;
                    end else if (r_in_byte >= r_word_start) begin
                        n_remaining = 32'd2;
                    end else begin
                        n_remaining = 32'd1;
                    end
                    n_phase = pfd_pkg::PH_DATA;
                end
            end
            pfd_pkg::PH_DATA: begin
                n_acc = r_acc | byte_lane;
                n_pos = pos_inc;
                if ({29'd0, pos_inc} >= r_remaining) begin
                    n_pos     = 3'd0;
                    res_valid = 1'b1;
                    res_kind  = pfd_pkg::RK_FIXED;
                    res_code  = r_event;
                    res_value = n_acc;
                    n_phase   = pfd_pkg::PH_EV_ID;
                    boundary  = 1'b1;
                end
            end
            pfd_pkg::PH_VARINT: begin
                n_acc = r_acc | varint_bits;
                if (r_in_byte[7]) begin
                    n_shift = (shift_inc > pfd_pkg::VARINT_SHIFT_MAX) ?
                              pfd_pkg::VARINT_SHIFT_MAX : shift_inc;
                end else begin
                    res_valid = 1'b1;
                    res_kind  = pfd_pkg::RK_TEXTLEN;
                    res_code  = r_event;
                    res_value = n_acc;
                    if (n_acc == 32'd0) begin
                        n_phase  = pfd_pkg::PH_EV_ID;
                        boundary = 1'b1;
                    end else begin
                        n_remaining = n_acc;
                        n_phase     = pfd_pkg::PH_PAYLOAD;
                    end
                end
            end
            pfd_pkg::PH_PAYLOAD: begin
                n_remaining = r_remaining - 32'd1;
                res_valid   = 1'b1;
                res_kind    = pfd_pkg::RK_PAYLOAD;
                res_code    = r_event;
                res_value   = {24'd0, r_in_byte};
                res_last    = (n_remaining == 32'd0);
                if (n_remaining == 32'd0) begin
                    n_phase  = pfd_pkg::PH_EV_ID;
                    boundary = 1'b1;
                end
            end
            default: begin
                // Error and done phases swallow every byte.
                active = 1'b0;
            end
        endcase

        // A failed check wins; otherwise a last byte off an event boundary is an early end.
        if (fail || (active && r_in_eof && !boundary)) begin
            n_phase   = pfd_pkg::PH_ERROR;
            res_valid = 1'b1;
            res_kind  = pfd_pkg::RK_ERROR;
            res_code  = 8'd0;
            res_value = 32'd0;
            res_err   = fail ? fail_kind : pfd_pkg::ERR_EARLY_END;
            res_last  = 1'b0;
        end else if (active && r_in_eof) begin
            n_phase = pfd_pkg::PH_DONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= pfd_pkg::PH_MAGIC;
            r_pos       <= 3'd0;
            r_acc       <= 32'd0;
            r_event     <= 8'd0;
            r_shift     <= 6'd0;
            r_remaining <= 32'd0;
            r_channels  <= 16'd0;
        end else if (proc_fire) begin
            r_phase     <= n_phase;
            r_pos       <= n_pos;
            r_acc       <= n_acc;
            r_event     <= n_event;
            r_shift     <= n_shift;
            r_remaining <= n_remaining;
            r_channels  <= n_channels;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc_fire) begin
            r_out_valid <= res_valid;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
        if (proc_fire) begin
            r_out_kind  <= res_kind;
            r_out_code  <= res_code;
            r_out_value <= res_value;
            r_out_err   <= res_err;
            r_out_last  <= res_last;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.result_kind  = r_out_kind;
    assign o_out.event_code   = r_out_code;
    assign o_out.event_value  = r_out_value;
    assign o_out.error_kind   = r_out_err;
    assign o_out.payload_last = r_out_last;

    // An error latches until reset.
    a_error_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == pfd_pkg::PH_ERROR |=> r_phase == pfd_pkg::PH_ERROR)
        else $error("parser left the error phase without reset");

    // End of file latches until reset.
    a_done_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == pfd_pkg::PH_DONE |=> r_phase == pfd_pkg::PH_DONE)
        else $error("parser left the done phase without reset");

    // While data bytes are gathered, the position stays below the event's byte count.
    a_data_position: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == pfd_pkg::PH_DATA |-> {29'd0, r_pos} < r_remaining)
        else $error("data byte position ran past the event size");

    // Only the closing payload byte of a text event is flagged as last.
    a_last_is_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_last |-> r_out_kind == pfd_pkg::RK_PAYLOAD)
        else $error("last flag on a result that is not a payload byte");

    // A parsed result with no room would be lost.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_out.ready |=> r_out_valid)
        else $error("pending result dropped before it was taken");

endmodule

`default_nettype wire

[verif/project_file_event_deframer_tb.sv]
// Self-checking testbench that streams one generated project file through the event deframer.
`timescale 1ns / 1ps

module project_file_event_deframer_tb;

    // Block parameters, kept at their defaults and passed explicitly.
    localparam int MAX_CHANNELS            = 1000;
    localparam int CHUNK_LENGTH_LIMIT_BITS = 28;
    localparam logic [31:0] CHUNK_LIMIT    = 32'd1 << CHUNK_LENGTH_LIMIT_BITS;

    // Register index that decodes to nothing; writes to it must be ignored.
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 12;
    // Cycles allowed for a request to pass the input and parse registers.
    localparam int SETTLE_CYCLES  = 8;
    localparam int TAIL_CYCLES    = 12;
    localparam int WATCHDOG_LIMIT = 3000;

    // Stimulus sizing: the random part is split evenly over the threshold settings.
    localparam int RANDOM_BYTES = 1500;
    localparam int PHASE_COUNT  = 10;
    localparam int PHASE_BYTES  = RANDOM_BYTES / PHASE_COUNT;

    // Flow control: random idling, a quiet window per side and one long receiver hold-off.
    localparam int IDLE_PERCENT     = 6;
    localparam int SEND_QUIET_FROM  = 600;
    localparam int SEND_QUIET_TO    = 900;
    localparam int RECV_QUIET_FROM  = 300;
    localparam int RECV_QUIET_TO    = 500;
    localparam int HOLD_AT_RESULT   = 150;
    localparam int HOLD_CYCLES      = 300;

    // What the driver does with the request at the head of its queue.
    typedef enum logic [1:0] {
        OP_BYTE,
        OP_CFG,
        OP_DRAIN
    } t_req_op;

    typedef struct packed {
        t_req_op    op;
        logic [7:0] data;
        logic       eof;
        logic [1:0] index;
    } t_file_req;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  code;
        logic [31:0] value;
        logic [2:0]  err;
        logic        last;
    } t_deframe_result;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_we = 1'b0;
    logic [1:0] i_cfg_index = '0;
    logic [7:0] i_cfg_data = '0;

    pfd_in_if  in_bus();
    pfd_out_if out_bus();

    project_file_event_deframer #(
        .MAX_CHANNELS            (MAX_CHANNELS),
        .CHUNK_LENGTH_LIMIT_BITS (CHUNK_LENGTH_LIMIT_BITS)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_bus),
        .o_out       (out_bus),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Requests waiting to be driven, and results the parser model has predicted.
    t_file_req       pending[$];
    t_deframe_result expected_results[$];

    int bytes_queued = 0;
    int bytes_accepted = 0;
    int results_seen = 0;
    int settings_applied = 0;
    int failures = 0;
    int settle_left = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    string ending_name;

    // Thresholds the stimulus generator assumes; they track the writes it queues.
    logic [7:0] gen_word_start  = pfd_pkg::WORD_START_RST;
    logic [7:0] gen_dword_start = pfd_pkg::DWORD_START_RST;
    logic [7:0] gen_text_start  = pfd_pkg::TEXT_START_RST;

    // Parser model state. Reset happens once, so the declaration values are the reset state.
    logic [7:0]  word_start_q  = pfd_pkg::WORD_START_RST;
    logic [7:0]  dword_start_q = pfd_pkg::DWORD_START_RST;
    logic [7:0]  text_start_q  = pfd_pkg::TEXT_START_RST;
    pfd_pkg::t_phase phase_q = pfd_pkg::PH_MAGIC;
    logic [2:0]  pos_q      = '0;
    logic [31:0] acc_q      = '0;
    logic [7:0]  event_q    = '0;
    logic [5:0]  shift_q    = '0;
    logic [31:0] left_q     = '0;
    logic [15:0] channels_q = '0;

    // Number of data bytes after an event id; zero marks a text event. The thresholds are
    // tested from the top down whatever their order.
    function automatic int unsigned event_data_len(input logic [7:0] id, input logic [7:0] w,
                                                   input logic [7:0] d, input logic [7:0] t);
        if (id >= t) return 0;
        if (id >= d) return 4;
        if (id >= w) return 2;
        return 1;
    endfunction

    // Collects a little-endian field of count bytes; true once the last byte is in.
    function automatic bit gather_le(inout logic [31:0] word, input logic [7:0] b,
                                     input int unsigned count);
        if (pos_q == 3'd0) word = '0;
        word = word | ({24'd0, b} << {pos_q[1:0], 3'b000});
        pos_q = pos_q + 3'd1;
        if (pos_q >= count) begin
            pos_q = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Advances the parser model by one accepted byte and queues the result it causes.
    function automatic void deframe_byte(input logic [7:0] b, input logic eof);
        t_deframe_result res;
        logic            have_res;
        logic            at_boundary;
        logic            failed;
        logic [2:0]      fail_kind;
        logic [63:0]     group;
        res = '0;
        have_res = 1'b0;
        at_boundary = 1'b0;
        failed = 1'b0;
        fail_kind = pfd_pkg::ERR_MAGIC;
        group = '0;
        // After an error or the end of the file every byte is dropped silently.
        if (phase_q == pfd_pkg::PH_ERROR || phase_q == pfd_pkg::PH_DONE) return;
        case (phase_q)
            pfd_pkg::PH_MAGIC: begin
                if (gather_le(acc_q, b, 4)) begin
                    if (acc_q != pfd_pkg::MAGIC_HEADER) begin
                        failed = 1'b1;
                        fail_kind = pfd_pkg::ERR_MAGIC;
                    end else phase_q = pfd_pkg::PH_HLEN;
                end
            end
            pfd_pkg::PH_HLEN: begin
                if (gather_le(acc_q, b, 4)) begin
                    if (acc_q != pfd_pkg::HDR_LENGTH) begin
                        failed = 1'b1;
                        fail_kind = pfd_pkg::ERR_HLEN;
                    end else phase_q = pfd_pkg::PH_TYPE;
                end
            end
            pfd_pkg::PH_TYPE: begin
                if (gather_le(acc_q, b, 2)) begin
                    if (acc_q != 32'd0) begin
                        failed = 1'b1;
                        fail_kind = pfd_pkg::ERR_TYPE;
                    end else phase_q = pfd_pkg::PH_CHAN;
                end
            end
            pfd_pkg::PH_CHAN: begin
                if (gather_le(acc_q, b, 2)) begin
                    if (acc_q[15:0] < 16'd1 || acc_q[15:0] > 16'(MAX_CHANNELS)) begin
                        failed = 1'b1;
                        fail_kind = pfd_pkg::ERR_CHANNELS;
                    end else begin
                        channels_q = acc_q[15:0];
                        phase_q = pfd_pkg::PH_PPQ;
                    end
                end
            end
            pfd_pkg::PH_PPQ: begin
                if (gather_le(acc_q, b, 2)) begin
                    res = '{pfd_pkg::RK_HEADER, 8'd0, {acc_q[15:0], channels_q}, 3'd0, 1'b0};
                    have_res = 1'b1;
                    phase_q = pfd_pkg::PH_CHUNK_ID;
                end
            end
            pfd_pkg::PH_CHUNK_ID: begin
                if (gather_le(acc_q, b, 4)) phase_q = pfd_pkg::PH_CHUNK_LEN;
            end
            pfd_pkg::PH_CHUNK_LEN: begin
                // The length limit is checked before the chunk id is looked at.
                if (gather_le(left_q, b, 4)) begin
                    if (left_q >= CHUNK_LIMIT) begin
                        failed = 1'b1;
                        fail_kind = pfd_pkg::ERR_CHUNK_LEN;
                    end else if (acc_q == pfd_pkg::MAGIC_DATA) begin
                        phase_q = pfd_pkg::PH_EV_ID;
                        at_boundary = 1'b1;
                    end else if (left_q == 32'd0) begin
                        phase_q = pfd_pkg::PH_CHUNK_ID;
                    end else begin
                        phase_q = pfd_pkg::PH_SKIP;
                    end
                end
            end
            pfd_pkg::PH_SKIP: begin
                left_q = left_q - 32'd1;
                if (left_q == 32'd0) phase_q = pfd_pkg::PH_CHUNK_ID;
            end
            pfd_pkg::PH_EV_ID: begin
                event_q = b;
                acc_q = '0;
                pos_q = '0;
                left_q = event_data_len(b, word_start_q, dword_start_q, text_start_q);
                if (left_q == 32'd0) begin
                    shift_q = '0;
                    phase_q = pfd_pkg::PH_VARINT;
                end else phase_q = pfd_pkg::PH_DATA;
            end
            pfd_pkg::PH_DATA: begin
                acc_q = acc_q | ({24'd0, b} << {pos_q[1:0], 3'b000});
                pos_q = pos_q + 3'd1;
                if (pos_q >= left_q) begin
                    pos_q = '0;
                    res = '{pfd_pkg::RK_FIXED, event_q, acc_q, 3'd0, 1'b0};
                    have_res = 1'b1;
                    phase_q = pfd_pkg::PH_EV_ID;
                    at_boundary = 1'b1;
                end
            end
            pfd_pkg::PH_VARINT: begin
                // Length bits from position 32 up fall away; the shift stops growing at 35.
                if (shift_q < 6'd32) begin
                    group = {57'd0, b[6:0]} << shift_q;
                    acc_q = acc_q | group[31:0];
                end
                if (b[7]) begin
                    shift_q = shift_q + pfd_pkg::VARINT_STEP;
                    if (shift_q > pfd_pkg::VARINT_SHIFT_MAX) shift_q = pfd_pkg::VARINT_SHIFT_MAX;
                end else begin
                    res = '{pfd_pkg::RK_TEXTLEN, event_q, acc_q, 3'd0, 1'b0};
                    have_res = 1'b1;
                    if (acc_q == 32'd0) begin
                        phase_q = pfd_pkg::PH_EV_ID;
                        at_boundary = 1'b1;
                    end else begin
                        left_q = acc_q;
                        phase_q = pfd_pkg::PH_PAYLOAD;
                    end
                end
            end
            pfd_pkg::PH_PAYLOAD: begin
                left_q = left_q - 32'd1;
                res = '{pfd_pkg::RK_PAYLOAD, event_q, {24'd0, b}, 3'd0, left_q == 32'd0};
                have_res = 1'b1;
                if (left_q == 32'd0) begin
                    phase_q = pfd_pkg::PH_EV_ID;
                    at_boundary = 1'b1;
                end
            end
            default: ;
        endcase
        // A header or chunk error on the last byte wins; otherwise a last byte that does
        // not close an event or the chunk header turns into an early-end error.
        if (!failed && eof && !at_boundary) begin
            failed = 1'b1;
            fail_kind = pfd_pkg::ERR_EARLY_END;
        end
        if (failed) begin
            phase_q = pfd_pkg::PH_ERROR;
            expected_results.insert(expected_results.size(),
                                    '{pfd_pkg::RK_ERROR, 8'd0, 32'd0, fail_kind, 1'b0});
        end else begin
            if (eof) phase_q = pfd_pkg::PH_DONE;
            if (have_res) expected_results.insert(expected_results.size(), res);
        end
    endfunction

    // Stimulus builders. They only fill the request queue; nothing here takes time.
    function automatic void push_byte(input logic [7:0] b, input logic eof = 1'b0);
        pending.insert(pending.size(), '{OP_BYTE, b, eof, 2'd0});
        bytes_queued++;
    endfunction

    function automatic void push_le(input logic [31:0] value, input int n);
        for (int i = 0; i < n; i++) push_byte(value[8 * i +: 8]);
    endfunction

    // Marks the most recently queued byte as the last one of the file.
    function automatic void mark_end();
        pending[pending.size() - 1].eof = 1'b1;
    endfunction

    // LEB128 length, optionally padded with redundant groups. Groups at shift 28 carry
    // junk in the bits that land at 32 and above; groups past that are pure junk.
    function automatic void push_varint(input logic [31:0] len, input int extra);
        int         groups;
        logic [7:0] g;
        groups = 1;
        while (groups < 5 && (len >> (7 * groups)) != 32'd0) groups++;
        groups += extra;
        for (int i = 0; i < groups; i++) begin
            if (i < 4) g = {1'b0, 7'((len >> (7 * i)) & 32'h7F)};
            else if (i == 4) g = {1'b0, 3'($urandom_range(7)), len[31:28]};
            else g = {1'b0, 7'($urandom_range(127))};
            if (i != groups - 1) g[7] = 1'b1;
            push_byte(g);
        end
    endfunction

    function automatic void push_fixed(input logic [7:0] id, input logic [31:0] value,
                                       input int n);
        push_byte(id);
        push_le(value, n);
    endfunction

    function automatic void push_text(input logic [7:0] id, input logic [31:0] len,
                                      input int extra);
        push_byte(id);
        push_varint(len, extra);
        for (int i = 0; i < int'(len); i++) push_byte(8'($urandom_range(255)));
    endfunction

    // Waits for the parser to drain, then loads a new set of class thresholds.
    function automatic void push_setting(input logic [7:0] w, input logic [7:0] d,
                                         input logic [7:0] t);
        pending.insert(pending.size(), '{OP_DRAIN, 8'd0, 1'b0, 2'd0});
        pending.insert(pending.size(), '{OP_CFG, w, 1'b0, pfd_pkg::CFG_WORD_START});
        pending.insert(pending.size(), '{OP_CFG, d, 1'b0, pfd_pkg::CFG_DWORD_START});
        pending.insert(pending.size(), '{OP_CFG, t, 1'b0, pfd_pkg::CFG_TEXT_START});
        gen_word_start = w;
        gen_dword_start = d;
        gen_text_start = t;
        settings_applied++;
    endfunction

    // Mostly uniform ids, with a share right at or just under a threshold.
    function automatic logic [7:0] pick_event_id();
        logic [7:0] border;
        case ($urandom_range(9))
            0: border = gen_word_start;
            1: border = gen_dword_start;
            2: border = gen_text_start;
            default: return 8'($urandom_range(255));
        endcase
        return border - 8'($urandom_range(1));
    endfunction

    function automatic void push_event(input logic [7:0] id);
        int unsigned n;
        int unsigned r;
        logic [31:0] value;
        logic [31:0] len;
        n = event_data_len(id, gen_word_start, gen_dword_start, gen_text_start);
        r = $urandom_range(99);
        if (n != 0) begin
            if (r < 10) value = '0;
            else if (r < 20) value = '1;
            else value = $urandom;
            push_fixed(id, value, int'(n));
        end else begin
            // Text lengths stay short; a few need a two-group varint.
            if (r < 8) len = 32'd0;
            else if (r < 80) len = $urandom_range(6, 1);
            else if (r < 97) len = $urandom_range(24, 7);
            else len = $urandom_range(160, 128);
            push_text(id, len, ($urandom_range(99) < 15) ? int'($urandom_range(5, 1)) : 0);
        end
    endfunction

    function automatic void push_random_events(input int n);
        int first;
        first = bytes_queued;
        while (bytes_queued - first < n) push_event(pick_event_id());
    endfunction

    // Request driver. Bytes go out in order; a drain request holds the line until no result
    // is outstanding, and configuration writes go out one per cycle while the parser is idle.
    always @(posedge i_clk) begin : feed_requests
        t_file_req head;
        logic      next_valid;
        logic      next_we;
        if (!i_rst_n) begin
            in_bus.valid <= 1'b0;
            in_bus.data_byte <= '0;
            in_bus.end_of_file <= 1'b0;
            i_cfg_we <= 1'b0;
            i_cfg_index <= '0;
            i_cfg_data <= '0;
        end else begin
            next_valid = in_bus.valid;
            next_we = 1'b0;
            if (in_bus.valid && in_bus.ready) begin
                deframe_byte(in_bus.data_byte, in_bus.end_of_file);
                bytes_accepted++;
                next_valid = 1'b0;
            end
            if (!next_valid) begin
                if (settle_left > 0) begin
                    settle_left--;
                end else if (pending.size() > 0) begin
                    head = pending[0];
                    case (head.op)
                        OP_BYTE: begin
                            // Random gaps, except in a window where the sender streams.
                            if ((bytes_accepted >= SEND_QUIET_FROM && bytes_accepted < SEND_QUIET_TO)
                                || $urandom_range(99) >= IDLE_PERCENT) begin
                                in_bus.data_byte <= head.data;
                                in_bus.end_of_file <= head.eof;
                                next_valid = 1'b1;
                                pending.delete(0);
                            end
                        end
                        OP_CFG: begin
                            i_cfg_index <= head.index;
                            i_cfg_data <= head.data;
                            next_we = 1'b1;
                            case (head.index)
                                pfd_pkg::CFG_WORD_START:  word_start_q = head.data;
                                pfd_pkg::CFG_DWORD_START: dword_start_q = head.data;
                                pfd_pkg::CFG_TEXT_START:  text_start_q = head.data;
                                default: ;
                            endcase
                            pending.delete(0);
                        end
                        default: begin
                            if (expected_results.size() == 0) begin
                                pending.delete(0);
                                settle_left = SETTLE_CYCLES;
                            end
                        end
                    endcase
                end
            end
            in_bus.valid <= next_valid;
            i_cfg_we <= next_we;
        end
    end

    // Result monitor and receiver. Each accepted result is checked against the oldest
    // prediction. Once, the receiver holds ready low long enough for the input to back up.
    always @(posedge i_clk) begin : check_results
        t_deframe_result want;
        logic            next_ready;
        if (!i_rst_n) begin
            out_bus.ready <= 1'b0;
        end else begin
            if (out_bus.valid && out_bus.ready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    $error("unexpected result: kind %0d code %0d value %0h error %0d",
                           out_bus.result_kind, out_bus.event_code, out_bus.event_value,
                           out_bus.error_kind);
                    failures++;
                end else begin
                    want = expected_results.pop_front();
                    if (out_bus.result_kind !== want.kind) begin
                        $error("result_kind: expected %0d, actual %0d", want.kind,
                               out_bus.result_kind);
                        failures++;
                    end
                    if (out_bus.event_code !== want.code) begin
                        $error("event_code: expected %0d, actual %0d", want.code,
                               out_bus.event_code);
                        failures++;
                    end
                    if (out_bus.event_value !== want.value) begin
                        $error("event_value: expected %0h, actual %0h", want.value,
                               out_bus.event_value);
                        failures++;
                    end
                    if (out_bus.error_kind !== want.err) begin
                        $error("error_kind: expected %0d, actual %0d", want.err,
                               out_bus.error_kind);
                        failures++;
                    end
                    if (out_bus.payload_last !== want.last) begin
                        $error("payload_last: expected %0d, actual %0d", want.last,
                               out_bus.payload_last);
                        failures++;
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                next_ready = 1'b0;
            end else if (!hold_done && results_seen >= HOLD_AT_RESULT) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                next_ready = 1'b0;
            end else begin
                next_ready = (results_seen >= RECV_QUIET_FROM && results_seen < RECV_QUIET_TO)
                             || $urandom_range(99) >= IDLE_PERCENT;
            end
            out_bus.ready <= next_ready;
        end
    end

    // Watchdog: too many cycles in a row with no request and no result moving ends the run.
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("timeout after %0d idle cycles", WATCHDOG_LIMIT);
        $display("project_file_event_deframer_tb NOT OK");
        $finish;
    end

    initial begin : run_file
        logic [15:0] channels;
        logic [15:0] ppq;
        int          skip_len;
        in_bus.valid = 1'b0;
        in_bus.data_byte = '0;
        in_bus.end_of_file = 1'b0;
        out_bus.ready = 1'b0;

        // File header. Since errors latch until reset and reset comes once, the whole run
        // is a single file: a valid header, a few chunks to skip, then the event stream.
        case ($urandom_range(2))
            0: channels = 16'd1;
            1: channels = 16'(MAX_CHANNELS);
            default: channels = 16'($urandom_range(MAX_CHANNELS - 1, 2));
        endcase
        case ($urandom_range(2))
            0: ppq = 16'h0000;
            1: ppq = 16'hFFFF;
            default: ppq = 16'($urandom);
        endcase
        push_le(pfd_pkg::MAGIC_HEADER, 4);
        push_le(pfd_pkg::HDR_LENGTH, 4);
        push_le(32'd0, 2);
        push_le({16'd0, channels}, 2);
        push_le({16'd0, ppq}, 2);

        // An empty chunk whose id differs from the data id in one letter, a chunk that
        // reuses the header id, and one with a random id and body, all skipped.
        push_le(pfd_pkg::MAGIC_DATA ^ 32'h0100_0000, 4);
        push_le(32'd0, 4);
        push_le(pfd_pkg::MAGIC_HEADER, 4);
        push_le(32'd5, 4);
        repeat (5) push_byte(8'($urandom_range(255)));
        skip_len = $urandom_range(12, 1);
        push_le($urandom, 4);
        push_le(skip_len, 4);
        repeat (skip_len) push_byte(8'($urandom_range(255)));
        // Data chunk, sometimes with the largest length that passes the check.
        push_le(pfd_pkg::MAGIC_DATA, 4);
        push_le($urandom_range(1) ? CHUNK_LIMIT - 32'd1 : 32'($urandom_range(4096)), 4);

        // Directed events under the reset thresholds: ids at both sides of every class
        // border, data words of all zeros and all ones, an empty text event, a one-byte
        // payload, a padded varint, a two-group varint and a varint past the shift limit.
        push_fixed(8'd0, 32'h0000_0000, 1);
        push_fixed(8'd63, 32'h0000_00FF, 1);
        push_fixed(pfd_pkg::WORD_START_RST, 32'h0000_FFFF, 2);
        push_fixed(pfd_pkg::DWORD_START_RST - 8'd1, $urandom, 2);
        push_fixed(pfd_pkg::DWORD_START_RST, 32'hFFFF_FFFF, 4);
        push_fixed(pfd_pkg::TEXT_START_RST - 8'd1, $urandom, 4);
        push_text(pfd_pkg::TEXT_START_RST, 32'd0, 0);
        push_text(8'd255, 32'd1, 0);
        push_text(8'd200, 32'd3, 3);
        push_text(8'd220, 32'd130, 0);
        push_text(8'd230, 32'd2, 6);
        push_random_events(PHASE_BYTES);

        // Threshold settings: all text, almost all one-byte, no two-byte class, low
        // values, out of order, random, and back to the reset values at the end.
        push_setting(8'd0, 8'd0, 8'd0);
        push_random_events(PHASE_BYTES);
        push_setting(8'd255, 8'd255, 8'd255);
        push_random_events(PHASE_BYTES);
        push_setting(8'd0, 8'd0, 8'd255);
        pending.insert(pending.size(), '{OP_CFG, 8'($urandom_range(255)), 1'b0, CFG_UNUSED});
        push_random_events(PHASE_BYTES);
        push_setting(8'd10, 8'd20, 8'd30);
        push_random_events(PHASE_BYTES);
        push_setting(8'd200, 8'd100, 8'd150);
        push_random_events(PHASE_BYTES);
        repeat (3) begin
            push_setting(8'($urandom_range(255)), 8'($urandom_range(255)),
                         8'($urandom_range(255)));
            push_random_events(PHASE_BYTES);
        end
        push_setting(pfd_pkg::WORD_START_RST, pfd_pkg::DWORD_START_RST,
                     pfd_pkg::TEXT_START_RST);
        push_random_events(PHASE_BYTES);

        // The file ends one of several ways; only one can be seen per reset.
        case ($urandom_range(6))
            0: begin
                ending_name = "last byte closes a fixed event";
                push_fixed(pfd_pkg::DWORD_START_RST, $urandom, 4);
                mark_end();
            end
            1: begin
                ending_name = "last byte is an empty text length";
                push_text(pfd_pkg::TEXT_START_RST, 32'd0, 0);
                mark_end();
            end
            2: begin
                ending_name = "last byte is the final payload byte";
                push_text(8'd255, 32'd3, 0);
                mark_end();
            end
            3: begin
                ending_name = "early end on an event id";
                push_byte(8'($urandom_range(255)));
                mark_end();
            end
            4: begin
                ending_name = "early end inside a data word";
                push_byte(pfd_pkg::DWORD_START_RST);
                push_le($urandom, 2);
                mark_end();
            end
            5: begin
                ending_name = "early end on a nonzero text length";
                push_byte(pfd_pkg::TEXT_START_RST + 8'd1);
                push_varint(32'd5, 0);
                mark_end();
            end
            default: begin
                ending_name = "early end inside a maximal-length text";
                push_byte(8'd254);
                push_varint(32'hFFFF_FFFF, 0);
                repeat (3) push_byte(8'($urandom_range(255)));
                mark_end();
            end
        endcase
        // Bytes after the end must be dropped without a result.
        repeat (4) push_byte(8'($urandom_range(255)), 1'($urandom_range(1)));

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(posedge i_clk);
        while (pending.size() != 0 || in_bus.valid || expected_results.size() != 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Streamed a %0d-byte file (%0d channels, ppq %0d) through %0d threshold settings,",
                 bytes_accepted, channels, ppq, settings_applied + 1);
        $display("checking %0d results; the file ended with: %s.", results_seen, ending_name);
        if (failures == 0) begin
            $display("project_file_event_deframer_tb OK");
        end else begin
            $display("project_file_event_deframer_tb NOT OK");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/core/pfd_pkg.sv
rtl/core/pfd_in_if.sv
rtl/core/pfd_out_if.sv
rtl/core/project_file_event_deframer.sv
verif/project_file_event_deframer_tb.sv
